@@ rtl/svo_pkg.sv @@
// Shared types, constants and helpers for the voxel octree point lookup.
// Holds the input and result beat structs, the sequencer states and popcount.
// No dependencies.
`default_nettype none

package svo_pkg;

	// Descriptor memory geometry
	localparam int StoreDepth = 32768;
	localparam int AddrW      = $clog2(StoreDepth);
	localparam int WordW      = 32;

	// Tree geometry
	localparam int MaxLevels  = 10;
	localparam int LevelW     = 4;
	localparam int CoordW     = 10;
	localparam int SumW       = CoordW + 1;

	// Descriptor word layout
	localparam int PtrW       = 15;
	localparam int FarBit     = 15;
	localparam int ValidLsb   = 16;
	localparam int LeafLsb    = 24;
	localparam int MaskW      = 8;
	localparam int OctW       = 3;

	// Configuration port
	localparam int CfgIdxW    = 1;
	localparam int CfgDataW   = 15;
	localparam logic [CfgIdxW-1:0] CfgRootNodeIndex = 1'd0;
	localparam logic [CfgIdxW-1:0] CfgTreeLevels    = 1'd1;
	localparam logic [LevelW-1:0]  TreeLevelsReset  = LevelW'(MaxLevels);

	// Operation codes
	localparam logic OpWrite  = 1'b0;
	localparam logic OpLookup = 1'b1;

	typedef struct packed {
		logic              operation;
		logic [AddrW-1:0]  write_address;
		logic [WordW-1:0]  write_word;
		logic [CoordW-1:0] pos_x;
		logic [CoordW-1:0] pos_y;
		logic [CoordW-1:0] pos_z;
	} svo_in_t;

	typedef struct packed {
		logic              found;
		logic [LevelW-1:0] depth_reached;
		logic [AddrW-1:0]  node_index;
		logic [CoordW-1:0] corner_x;
		logic [CoordW-1:0] corner_y;
		logic [CoordW-1:0] corner_z;
	} svo_out_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EVAL,
		S_FAR,
		S_DONE
	} svo_state_t;

	// Count set bits of a mask byte
	function automatic logic [OctW:0] popcount8(input logic [MaskW-1:0] v);
		logic [OctW:0] n;
		n = '0;
		for (int i = 0; i < MaskW; i++) begin
			n = n + (OctW+1)'(v[i]);
		end
		return n;
	endfunction

endpackage

`default_nettype wire

@@ rtl/sparse_voxel_octree_point_lookup.sv @@
// Top level of the voxel octree point lookup: descriptor memory, walk
// sequencer and result register. Depends on svo_pkg.
`default_nettype none

// A write beat stores one descriptor word. A lookup beat walks the octree
// from the root: the root descriptor is fetched first, then each level is
// evaluated and, for an inner octant, its child is read, directly through a
// near pointer or through a far pointer by reading the pointer word first;
// last the result is handed to the output register. Each step waits on the
// single read port of the descriptor memory.
// The input is stalled for the whole walk; a finished result may still wait in
// the output register while the next beat is taken. Reading a descriptor that
// was never written gives undefined fields; the memory needs no clearing pass.
module sparse_voxel_octree_point_lookup
	import svo_pkg::*;
(
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	input  svo_in_t             in_data,
	output logic                out_valid,
	input  wire                 out_stall,
	output svo_out_t            out_data,
	input  wire                 cfg_we,
	input  wire [CfgIdxW-1:0]   cfg_index,
	input  wire [CfgDataW-1:0]  cfg_data
);

	// Configuration registers
	logic [AddrW-1:0]  root_node_index_q;
	logic [LevelW-1:0] tree_levels_q;

	// Sequencer and walk registers
	svo_state_t        state_q, state_d;
	logic [CoordW-1:0] pos_x_q, pos_y_q, pos_z_q;
	logic [CoordW-1:0] cx_q, cy_q, cz_q;
	logic [AddrW-1:0]  cur_q;
	logic [LevelW-1:0] depth_q;
	logic [LevelW-1:0] lvl_q;
	logic [OctW-1:0]   count_q;
	logic              found_q;

	// Memory and result
	logic [WordW-1:0]  mem [StoreDepth];
	logic [WordW-1:0]  rd_q;
	logic              out_valid_q;
	svo_out_t          out_q;

	// Combinational signals
	logic              in_accept;
	logic              out_free;
	logic [LevelW-1:0] levels_clamped;
	logic [SumW-1:0]   half;
	logic [SumW-1:0]   sum_x, sum_y, sum_z;
	logic              up_x, up_y, up_z;
	logic [OctW-1:0]   oct;
	logic [MaskW-1:0]  valid_mask, leaf_mask;
	logic              hit_valid, hit_leaf, is_far;
	logic [OctW-1:0]   count;
	logic [AddrW-1:0]  add_a, add_b;
	logic [OctW-1:0]   add_c;
	logic [AddrW-1:0]  add_sum;
	logic              rd_en, wr_en;
	logic [AddrW-1:0]  rd_addr;

	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign levels_clamped = (tree_levels_q > LevelW'(MaxLevels)) ?
		LevelW'(MaxLevels) : tree_levels_q;

	// Octant choice and descriptor decode for the current level
	always_comb begin
		half  = SumW'(1) << (lvl_q - LevelW'(1));
		sum_x = {1'b0, cx_q} + half;
		sum_y = {1'b0, cy_q} + half;
		sum_z = {1'b0, cz_q} + half;
		up_x  = {1'b0, pos_x_q} >= sum_x;
		up_y  = {1'b0, pos_y_q} >= sum_y;
		up_z  = {1'b0, pos_z_q} >= sum_z;
		oct   = {up_z, up_y, up_x};
		valid_mask = rd_q[ValidLsb +: MaskW];
		leaf_mask  = rd_q[LeafLsb +: MaskW];
		hit_valid  = valid_mask[oct];
		hit_leaf   = leaf_mask[oct];
		is_far     = rd_q[FarBit];
		count      = OctW'(popcount8(valid_mask & ((MaskW'(1) << oct) - MaskW'(1))));
	end

	// Shared address adder
	assign add_sum = add_a + add_b + AddrW'(add_c);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_accept && in_data.operation == OpLookup) begin
					state_d = (levels_clamped == '0) ? S_DONE : S_EVAL;
				end
			end
			S_EVAL: begin
				if (!hit_valid || hit_leaf) begin
					state_d = S_DONE;
				end else if (is_far) begin
					state_d = S_FAR;
				end else if (lvl_q == LevelW'(1)) begin
					state_d = S_DONE;
				end
			end
			S_FAR: begin
				state_d = (lvl_q == '0) ? S_DONE : S_EVAL;
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control outputs: memory port and adder operands
	always_comb begin
		in_stall = (state_q != S_IDLE);
		wr_en    = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = add_sum;
		add_a    = cur_q;
		add_b    = rd_q[PtrW-1:0];
		add_c    = '0;
		case (state_q)
			S_IDLE: begin
				wr_en   = in_accept && in_data.operation == OpWrite;
				rd_en   = in_accept && in_data.operation == OpLookup;
				rd_addr = root_node_index_q;
			end
			S_EVAL: begin
				// far hop reads the pointer word, near hop reads the child
				rd_en = hit_valid && !hit_leaf;
				add_c = is_far ? '0 : count;
			end
			S_FAR: begin
				rd_en = 1'b1;
				add_a = rd_q[AddrW-1:0];
				add_b = '0;
				add_c = count_q;
			end
			S_DONE: begin
				rd_en = 1'b0;
			end
			default: rd_en = 1'b0;
		endcase
	end

	// Descriptor memory: one write or one read a cycle, registered read data
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[in_data.write_address] <= in_data.write_word;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_node_index_q <= '0;
			tree_levels_q     <= TreeLevelsReset;
		end else if (cfg_we) begin
			case (cfg_index)
				CfgRootNodeIndex: root_node_index_q <= cfg_data[AddrW-1:0];
				CfgTreeLevels:    tree_levels_q     <= cfg_data[LevelW-1:0];
				default:          root_node_index_q <= root_node_index_q;
			endcase
		end
	end

	// Sequencer state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Walk registers: start, descend, far hop
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_accept && in_data.operation == OpLookup) begin
					pos_x_q <= in_data.pos_x;
					pos_y_q <= in_data.pos_y;
					pos_z_q <= in_data.pos_z;
					cx_q    <= '0;
					cy_q    <= '0;
					cz_q    <= '0;
					cur_q   <= root_node_index_q;
					depth_q <= '0;
					lvl_q   <= levels_clamped;
					found_q <= 1'b1;
				end
			end
			S_EVAL: begin
				if (up_x) cx_q <= sum_x[CoordW-1:0];
				if (up_y) cy_q <= sum_y[CoordW-1:0];
				if (up_z) cz_q <= sum_z[CoordW-1:0];
				if (!hit_valid) begin
					found_q <= 1'b0;
				end else if (!hit_leaf) begin
					depth_q <= depth_q + LevelW'(1);
					lvl_q   <= lvl_q - LevelW'(1);
					count_q <= count;
					if (!is_far) begin
						cur_q <= add_sum;
					end
				end
			end
			S_FAR: begin
				cur_q <= add_sum;
			end
			default: begin
				cur_q <= cur_q;
			end
		endcase
	end

	// Result register: load when the slot is free
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_q.found         <= found_q;
			out_q.depth_reached <= depth_q;
			out_q.node_index    <= cur_q;
			out_q.corner_x      <= cx_q;
			out_q.corner_y      <= cy_q;
			out_q.corner_z      <= cz_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// A far hop always follows a descending evaluation
	a_far_after_eval: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FAR |-> $past(state_q) == S_EVAL)
		else $error("far hop entered without a descending evaluation");

	// Evaluation only runs with levels left to walk
	a_eval_levels: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EVAL |-> lvl_q != '0)
		else $error("evaluation with no level left");

	// The walk never descends past the deepest level
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE |-> depth_q <= LevelW'(MaxLevels))
		else $error("depth beyond the deepest level");

	// A new result only comes from a finished walk
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_DONE)
		else $error("result raised outside the finish state");

	// No beat is taken while a walk is in flight
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EVAL || state_q == S_FAR) |-> !in_accept)
		else $error("input beat taken during a walk");

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking testbench for the voxel octree point lookup block.
// Drives write and lookup beats, gives or predicts every lookup result and checks it.
// Depends on svo_pkg and sparse_voxel_octree_point_lookup.
`timescale 1ns / 100ps

module tb_top;
	import svo_pkg::*;

	typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t         kind;
		svo_in_t           beat;
		bit                typed;
		svo_out_t          want;
		logic [AddrW-1:0]  root;
		logic [LevelW-1:0] levels;
	} row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	svo_in_t             in_data = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	svo_out_t            out_data;
	logic                cfg_we = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;

	// Shadow of the descriptor memory and of the two registers
	logic [WordW-1:0]    desc_mem [StoreDepth];
	bit                  desc_written [StoreDepth];
	logic [AddrW-1:0]    root_idx = '0;
	logic [LevelW-1:0]   tree_lv = TreeLevelsReset;

	svo_out_t            expected_lookups[$];
	row_t                plan[$];
	int                  mismatches = 0;
	int                  idle_pct = 0;
	int                  stall_pct = 0;

	sparse_voxel_octree_point_lookup dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	function automatic int count_ones(input logic [MaskW-1:0] m);
		int n;
		n = 0;
		for (int i = 0; i < MaskW; i++) n += m[i];
		return n;
	endfunction

	// Pick one set bit of a non-empty mask at random
	function automatic int pick_bit(input logic [MaskW-1:0] m);
		int k;
		k = $urandom_range(0, count_ones(m) - 1);
		for (int i = 0; i < MaskW; i++) begin
			if (m[i]) begin
				if (k == 0) return i;
				k--;
			end
		end
		return 0;
	endfunction

	function automatic int eff_levels();
		return (tree_lv > MaxLevels) ? MaxLevels : tree_lv;
	endfunction

	// Read the shadow memory; clear ok if the entry was never written
	function automatic logic [WordW-1:0] read_desc(input logic [AddrW-1:0] a, inout bit ok);
		ok &= desc_written[a];
		return desc_mem[a];
	endfunction

	// Child descriptor address of a valid octant, through a near or far pointer
	function automatic logic [AddrW-1:0] child_of(input logic [AddrW-1:0] cur,
			input logic [WordW-1:0] head, input int oct, inout bit ok);
		logic [MaskW-1:0] valid;
		logic [AddrW-1:0] rank;
		logic [AddrW-1:0] far_at;
		logic [WordW-1:0] far_word;
		valid = head[ValidLsb +: MaskW];
		rank = AddrW'(count_ones(valid & ((8'd1 << oct) - 8'd1)));
		if (head[FarBit]) begin
			far_at = cur + head[PtrW-1:0];
			far_word = read_desc(far_at, ok);
			return far_word[AddrW-1:0] + rank;
		end
		return cur + head[PtrW-1:0] + rank;
	endfunction

	// Walk the shadow tree for one lookup; ok says every read hit a written entry
	function automatic svo_out_t walk_octree(input svo_in_t b, output bit ok);
		svo_out_t          r;
		logic [AddrW-1:0]  cur;
		logic [WordW-1:0]  head;
		logic [MaskW-1:0]  valid;
		logic [MaskW-1:0]  leaf;
		int                dim, half, oct, cx, cy, cz, depth;
		bit                found;
		ok = 1'b1;
		dim = 1 << eff_levels();
		cx = 0;
		cy = 0;
		cz = 0;
		depth = 0;
		found = 1'b1;
		cur = root_idx;
		head = read_desc(cur, ok);
		while (dim > 1) begin
			half = dim >> 1;
			oct = 0;
			if (b.pos_x >= cx + half) begin
				cx += half;
				oct |= 1;
			end
			if (b.pos_y >= cy + half) begin
				cy += half;
				oct |= 2;
			end
			if (b.pos_z >= cz + half) begin
				cz += half;
				oct |= 4;
			end
			valid = head[ValidLsb +: MaskW];
			leaf = head[LeafLsb +: MaskW];
			if (!valid[oct]) begin
				found = 1'b0;
				break;
			end
			if (leaf[oct]) break;
			depth++;
			dim = half;
			cur = child_of(cur, head, oct, ok);
			head = read_desc(cur, ok);
		end
		r.found = found;
		r.depth_reached = LevelW'(depth);
		r.node_index = cur;
		r.corner_x = CoordW'(cx);
		r.corner_y = CoordW'(cy);
		r.corner_z = CoordW'(cz);
		return r;
	endfunction

	// Build a lookup coordinate that mostly follows inner octants of the tree
	function automatic svo_in_t aim_lookup();
		svo_in_t           b;
		logic [AddrW-1:0]  cur;
		logic [WordW-1:0]  head;
		logic [MaskW-1:0]  open;
		int                lv, oct, pos;
		bit                ok;
		lv = eff_levels();
		ok = 1'b1;
		b.operation = OpLookup;
		b.write_address = AddrW'($urandom);
		b.write_word = $urandom;
		b.pos_x = CoordW'($urandom);
		b.pos_y = CoordW'($urandom);
		b.pos_z = CoordW'($urandom);
		// keep the coordinate inside the cube most of the time
		if ($urandom_range(0, 9) != 0) begin
			b.pos_x = b.pos_x & CoordW'((1 << lv) - 1);
			b.pos_y = b.pos_y & CoordW'((1 << lv) - 1);
			b.pos_z = b.pos_z & CoordW'((1 << lv) - 1);
		end
		cur = root_idx;
		head = read_desc(cur, ok);
		for (int d = 0; d < lv; d++) begin
			open = head[ValidLsb +: MaskW] & ~head[LeafLsb +: MaskW];
			if (open != 0 && $urandom_range(0, 9) < 8) oct = pick_bit(open);
			else oct = $urandom_range(0, 7);
			pos = lv - 1 - d;
			b.pos_x[pos] = oct[0];
			b.pos_y[pos] = oct[1];
			b.pos_z[pos] = oct[2];
			if (!open[oct]) break;
			cur = child_of(cur, head, oct, ok);
			head = read_desc(cur, ok);
		end
		return b;
	endfunction

	function automatic svo_out_t make_result(input bit found, input int depth,
			input int node, input int cx, input int cy, input int cz);
		svo_out_t r;
		r.found = found;
		r.depth_reached = LevelW'(depth);
		r.node_index = AddrW'(node);
		r.corner_x = CoordW'(cx);
		r.corner_y = CoordW'(cy);
		r.corner_z = CoordW'(cz);
		return r;
	endfunction

	task automatic row_write(input int addr, input logic [WordW-1:0] word);
		row_t r;
		r = '{kind: ROW_BEAT, default: '0};
		r.beat.operation = OpWrite;
		r.beat.write_address = AddrW'(addr);
		r.beat.write_word = word;
		plan.insert(plan.size(), r);
	endtask

	task automatic row_look(input int x, input int y, input int z, input bit typed,
			input svo_out_t want);
		row_t r;
		r = '{kind: ROW_BEAT, default: '0};
		r.beat.operation = OpLookup;
		r.beat.pos_x = CoordW'(x);
		r.beat.pos_y = CoordW'(y);
		r.beat.pos_z = CoordW'(z);
		r.typed = typed;
		r.want = want;
		plan.insert(plan.size(), r);
	endtask

	task automatic row_cfg(input int root, input int levels);
		row_t r;
		r = '{kind: ROW_CFG, default: '0};
		r.root = AddrW'(root);
		r.levels = LevelW'(levels);
		plan.insert(plan.size(), r);
	endtask

	// Offer one beat, hold it until taken, then update the shadow state
	task automatic send_beat(input svo_in_t b, input svo_out_t want);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		do @(posedge clk); while (in_stall);
		if (b.operation == OpWrite) begin
			desc_mem[b.write_address] = b.write_word;
			desc_written[b.write_address] = 1'b1;
		end else begin
			expected_lookups.insert(expected_lookups.size(), want);
		end
	endtask

	task automatic send_write(input logic [AddrW-1:0] addr, input logic [WordW-1:0] word);
		svo_in_t b;
		b.operation = OpWrite;
		b.write_address = addr;
		b.write_word = word;
		b.pos_x = CoordW'($urandom);
		b.pos_y = CoordW'($urandom);
		b.pos_z = CoordW'($urandom);
		send_beat(b, '0);
	endtask

	// Hold the input until every lookup has answered and the block is idle
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_lookups.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic set_config(input logic [AddrW-1:0] root, input logic [LevelW-1:0] lv);
		cfg_we <= 1'b1;
		cfg_index <= CfgRootNodeIndex;
		cfg_data <= root;
		@(posedge clk);
		root_idx = root;
		cfg_index <= CfgTreeLevels;
		cfg_data <= {(CfgDataW-LevelW)'($urandom), lv};
		@(posedge clk);
		tree_lv = lv;
		cfg_we <= 1'b0;
	endtask

	// Write a random tree at root, depth first, with one or two inner octants per node while the node budget lasts
	task automatic grow_tree(input logic [AddrW-1:0] root);
		logic [AddrW-1:0]  node_at[$];
		int                node_lvl[$];
		logic [AddrW-1:0]  addr, block, far_slot, next_free;
		logic [MaskW-1:0]  valid, leaf, inner;
		logic [WordW-1:0]  word;
		int                lvl, budget, lv;
		lv = eff_levels();
		budget = 24;
		next_free = root + 1'b1;
		node_at.insert(node_at.size(), root);
		node_lvl.insert(node_lvl.size(), 0);
		while (node_at.size() != 0) begin
			addr = node_at.pop_back();
			lvl = node_lvl.pop_back();
			word = $urandom;
			// nodes below the bottom level are read but never examined
			if (lvl < lv) begin
				valid = word[ValidLsb +: MaskW] | (8'd1 << $urandom_range(0, 7));
				inner = '0;
				if (budget > 0) begin
					repeat ($urandom_range(1, 2)) inner[pick_bit(valid)] = 1'b1;
				end
				leaf = (valid & ~inner) | (word[LeafLsb +: MaskW] & ~valid);
				word[ValidLsb +: MaskW] = valid;
				word[LeafLsb +: MaskW] = leaf;
				if (inner != 0) begin
					block = next_free;
					next_free += AddrW'(count_ones(valid));
					word[FarBit] = $urandom_range(0, 1);
					if (word[FarBit]) begin
						far_slot = next_free;
						next_free += 1'b1;
						word[PtrW-1:0] = far_slot - addr;
						send_write(far_slot, {(WordW-AddrW)'($urandom), block});
					end else begin
						word[PtrW-1:0] = block - addr;
					end
					for (int o = 0; o < MaskW; o++) begin
						if (inner[o]) begin
							node_at.insert(node_at.size(), block
								+ AddrW'(count_ones(valid & ((8'd1 << o) - 8'd1))));
							node_lvl.insert(node_lvl.size(), lvl + 1);
							budget--;
						end
					end
				end
			end
			send_write(addr, word);
		end
	endtask

	// Check each result beat against the oldest expectation; vary the stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_lookups.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch at %0t: result beat with nothing expected", $time);
			end else if (out_data !== expected_lookups[0]) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch at %0t: expected found=%0d depth=%0d node=%0d",
						$time, expected_lookups[0].found,
						expected_lookups[0].depth_reached, expected_lookups[0].node_index,
						" corner=(%0d,%0d,%0d)", expected_lookups[0].corner_x,
						expected_lookups[0].corner_y, expected_lookups[0].corner_z,
						", got found=%0d depth=%0d node=%0d", out_data.found,
						out_data.depth_reached, out_data.node_index,
						" corner=(%0d,%0d,%0d)",
						out_data.corner_x, out_data.corner_y, out_data.corner_z);
				void'(expected_lookups.pop_front());
			end else begin
				void'(expected_lookups.pop_front());
			end
		end
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	initial begin
		int         phase_lv [8] = '{10, 10, 1, 4, 13, 7, 0, 10};
		int         idle_set [4] = '{0, 85, 0, 32};
		int         stall_set [4] = '{0, 0, 85, 32};
		svo_out_t   want;
		svo_in_t    probe;
		bit         ok;
		logic [AddrW-1:0] root;

		// Directed rows: empty root, all-leaf root, near and far children,
		// address wrap at the top of memory, zero levels and clamped levels
		row_write(0, 32'h0000_0000);
		row_look(0, 0, 0, 1'b1, make_result(0, 0, 0, 0, 0, 0));
		row_look(1023, 1023, 1023, 1'b1, make_result(0, 0, 0, 512, 512, 512));
		row_write(0, 32'hFFFF_0000);
		row_look(1023, 0, 0, 1'b1, make_result(1, 0, 0, 512, 0, 0));
		row_write(0, 32'h0081_0001);
		row_write(1, 32'hFFFF_0000);
		row_write(2, 32'hFF00_0000);
		row_look(0, 0, 0, 1'b1, make_result(1, 1, 1, 0, 0, 0));
		row_look(1023, 1023, 1023, 1'b1, make_result(0, 1, 2, 768, 768, 768));
		row_look(600, 0, 0, 1'b1, make_result(0, 0, 0, 512, 0, 0));
		row_write(5, 32'hFFFF_8001);
		row_write(0, 32'h0081_8005);
		row_look(0, 0, 0, 1'b1, make_result(1, 1, 1, 0, 0, 0));
		row_look(1023, 1023, 1023, 1'b1, make_result(0, 1, 2, 768, 768, 768));
		row_look(300, 700, 5, 1'b0, '0);
		row_look(900, 600, 700, 1'b0, '0);
		row_cfg(32767, 1);
		row_write(32767, 32'h0003_0001);
		row_look(0, 0, 0, 1'b1, make_result(1, 1, 0, 0, 0, 0));
		row_look(1, 0, 0, 1'b1, make_result(1, 1, 1, 1, 0, 0));
		row_look(0, 1023, 0, 1'b1, make_result(0, 0, 32767, 0, 1, 0));
		row_cfg(32767, 0);
		row_look(1023, 1023, 1023, 1'b1, make_result(1, 0, 32767, 0, 0, 0));
		row_cfg(0, 15);
		row_look(1023, 1023, 1023, 1'b1, make_result(0, 1, 2, 768, 768, 768));
		row_look(512, 0, 1023, 1'b1, make_result(0, 0, 0, 512, 0, 512));

		// Hold reset, then release it
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed rows
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				drain();
				set_config(plan[i].root, plan[i].levels);
			end else begin
				want = plan[i].want;
				if (plan[i].beat.operation == OpLookup && !plan[i].typed)
					want = walk_octree(plan[i].beat, ok);
				send_beat(plan[i].beat, want);
			end
		end

		// Random phases: fresh tree per setting, then lookups mixed with stray writes
		for (int p = 0; p < 8; p++) begin
			drain();
			idle_pct = idle_set[p % 4];
			stall_pct = stall_set[p % 4];
			root = (p == 1) ? AddrW'(32767) : (p == 2) ? AddrW'(0) : AddrW'($urandom);
			set_config(root, LevelW'(phase_lv[p]));
			grow_tree(root_idx);
			for (int n = 0; n < 48; n++) begin
				if (p == 3 && n == 24) drain();
				if ($urandom_range(0, 99) < 15) begin
					send_write(AddrW'($urandom), $urandom);
				end else begin
					// skip any lookup that would read an unwritten entry
					ok = 1'b0;
					for (int t = 0; t < 8 && !ok; t++) begin
						probe = aim_lookup();
						want = walk_octree(probe, ok);
					end
					if (ok) send_beat(probe, want);
					else send_write(AddrW'($urandom), $urandom);
				end
			end
		end

		drain();
		if (mismatches == 0 && expected_lookups.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// Stop a hung run
	initial begin
		#(10_000_000);
		$display("FAILED: results differ");
		$finish;
	end

endmodule
